### hdl/frbcc_pkg.sv
`default_nettype none

package frbcc_pkg;

  // Line bytes with a fixed meaning.
  localparam logic [7:0] FlagByte = 8'h5c;
  localparam logic [7:0] EscByte  = 8'h5d;
  localparam logic [7:0] EscFlag  = 8'h7c;
  localparam logic [7:0] EscEsc   = 8'h7d;

  localparam int unsigned MaxPayloadDef = 1024;

  // Widths of the result word fields.
  localparam int unsigned DataW     = 8;
  localparam int unsigned KindW     = 4;
  localparam int unsigned LenFieldW = 11;
  localparam int unsigned LenSat    = 2047;

  // Control kinds: the two information kinds come first.
  localparam int unsigned NumKinds     = 9;
  localparam int unsigned NumSup       = 7;
  localparam logic [KindW-1:0] KindFirstSup = 4'd2;

  // Result queue depth, a power of two of at least two.
  localparam int unsigned OutDepth = 4;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 56;

  typedef enum logic [CfgIdxW-1:0] {
    CfgAddrA = 3'd0,
    CfgAddrB = 3'd1,
    CfgInfo0 = 3'd2,
    CfgInfo1 = 3'd3,
    CfgSup   = 3'd4
  } cfg_idx_e;

  localparam logic [7:0]          AddrARst = 8'd3;
  localparam logic [7:0]          AddrBRst = 8'd1;
  localparam logic [7:0]          Info0Rst = 8'd0;
  localparam logic [7:0]          Info1Rst = 8'd64;
  localparam logic [CfgDataW-1:0] SupRst   = 56'd36311942822561539;

  typedef enum logic [1:0] {
    StCtrlOk   = 2'd0,
    StInfoOk   = 2'd1,
    StInfoErr  = 2'd2,
    StOverlong = 2'd3
  } status_e;

  typedef struct packed {
    logic                 is_end;
    logic [DataW-1:0]     data;
    logic                 addr_sel;
    logic [KindW-1:0]     kind;
    status_e              status;
    logic [LenFieldW-1:0] len;
  } res_t;

endpackage

`default_nettype wire

### hdl/frame_receiver_destuff_bcc_core.sv
`default_nettype none

// Byte-stuffed frame receiver. Line bytes arrive one word per handshake on the
// input channel; the block hunts for the flag 0x5c, checks an address byte,
// a control byte and a header check (address XOR control), then either
// closes a supervisory frame on the next flag or destuffs the payload of an
// information frame and hands it on one byte late, so that the final byte
// (the payload check) is never passed on. Each closing flag gives an end
// word carrying the frame kind, a check status and the payload length.
// One input word is taken in every clock cycle unless the input stalls: the
// frame state, the destuffing and the running XOR are all updated in the
// cycle of the handshake, and its result words are registered. A single line
// byte can give two result words (a held payload byte and an end word, or
// two payload bytes after a broken escape); these go into a four-word result
// queue, and the input stalls only while fewer than two queue slots are free,
// so the input runs at full rate whenever the output drains one word a cycle.
// Configuration writes may only be made while no frame is being processed.
module frame_receiver_destuff_bcc_core import frbcc_pkg::*; #(
  parameter int unsigned MaxPayload = MaxPayloadDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [CfgDataW-1:0]  cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [DataW-1:0]     rx_byte_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic                      is_end_o,
  output logic [DataW-1:0]          data_byte_o,
  output logic                      address_sel_o,
  output logic [KindW-1:0]          ctrl_kind_o,
  output logic [1:0]                status_o,
  output logic [LenFieldW-1:0]      payload_len_o
);

  // The byte counter must reach one past the limit to mark an overlong frame.
  localparam int unsigned CntW = $clog2(MaxPayload + 2);
  localparam int unsigned LenW = (CntW > LenFieldW) ? CntW : LenFieldW;
  localparam logic [CntW-1:0] CntMax  = CntW'(MaxPayload);
  localparam logic [CntW-1:0] CntOver = CntW'(MaxPayload + 1);
  localparam int unsigned PtrW = $clog2(OutDepth);

  typedef enum logic [2:0] {
    PhHunt = 3'd0,
    PhFlag = 3'd1,
    PhAddr = 3'd2,
    PhCtrl = 3'd3,
    PhBcc  = 3'd4,
    PhData = 3'd5
  } phase_e;

  // Payload state: the held-back byte, the XOR of the bytes passed on so far
  // and how many were passed on.
  typedef struct packed {
    logic             valid;
    logic [DataW-1:0] held;
    logic [DataW-1:0] chk;
    logic [CntW-1:0]  cnt;
  } dstate_t;

  typedef struct packed {
    dstate_t          s;
    logic             emit;
    logic [DataW-1:0] data;
  } push_t;

  localparam dstate_t DsClear = '0;

  // Takes one destuffed byte and releases the previously held one, unless the
  // frame has already reached its length limit.
  function automatic push_t push_fn(input dstate_t s, input logic [DataW-1:0] b);
    push_t r;
    r.s    = s;
    r.emit = 1'b0;
    r.data = s.held;
    if (s.valid) begin
      if (s.cnt < CntMax) begin
        r.emit  = 1'b1;
        r.s.chk = s.chk ^ s.held;
        r.s.cnt = s.cnt + 1'b1;
      end else begin
        r.s.cnt = CntOver;
      end
    end
    r.s.held  = b;
    r.s.valid = 1'b1;
    return r;
  endfunction

  // Configuration registers.
  logic [DataW-1:0]    addr_a_q, addr_b_q, info0_q, info1_q;
  logic [CfgDataW-1:0] sup_q;

  // Frame state.
  phase_e           phase_q, phase_d;
  logic             sel_q, sel_d;
  logic [KindW-1:0] kind_q, kind_d;
  logic             esc_q, esc_d;
  dstate_t          ds_q, ds_d;

  // Result queue.
  res_t             res_q [OutDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]    fill_q, fill_d;

  logic             in_acc, pop;
  logic [DataW-1:0] codes [NumKinds];
  logic [DataW-1:0] cur_code, cur_addr;
  logic             kind_hit;
  logic [KindW-1:0] kind_match;

  logic             p1_do, p2_do, end_do, data_path, esc_in;
  logic [DataW-1:0] p1_val, p2_val;
  dstate_t          ds_in, ds_mid, ds_fin;
  push_t            pa, pb;
  logic             e1, e2;
  res_t             dr1, dr2, er, slot0, slot1;
  logic [1:0]       n_wr;
  status_e          end_status;
  logic [CntW-1:0]  end_len;
  logic [LenW-1:0]  end_len_x;

  assign in_stall_o  = fill_q > (PtrW+1)'(OutDepth - 2);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = fill_q != '0;
  assign pop         = out_valid_o && !out_stall_i;

  // Control code table: the two information codes, then the seven packed
  // supervisory codes.
  always_comb begin
    codes[0] = info0_q;
    codes[1] = info1_q;
    for (int k = 0; k < NumSup; k++) begin
      codes[k + 2] = sup_q[DataW*k +: DataW];
    end
  end

  // Lowest matching kind wins when codes are equal.
  always_comb begin
    kind_hit   = 1'b0;
    kind_match = '0;
    for (int k = NumKinds - 1; k >= 0; k--) begin
      if (rx_byte_i == codes[k]) begin
        kind_hit   = 1'b1;
        kind_match = KindW'(k);
      end
    end
  end

  assign cur_code = codes[kind_q];
  assign cur_addr = sel_q ? addr_b_q : addr_a_q;

  always_comb begin
    phase_d   = phase_q;
    sel_d     = sel_q;
    kind_d    = kind_q;
    esc_d     = esc_q;
    ds_in     = ds_q;
    esc_in    = esc_q;
    data_path = 1'b0;
    end_do    = 1'b0;
    p1_do     = 1'b0;
    p1_val    = '0;
    p2_do     = 1'b0;
    p2_val    = '0;

    if (in_acc) begin
      unique case (phase_q)
        PhHunt: begin
          if (rx_byte_i == FlagByte) phase_d = PhFlag;
        end
        PhFlag: begin
          priority if (rx_byte_i == addr_a_q) begin
            sel_d   = 1'b0;
            phase_d = PhAddr;
          end else if (rx_byte_i == addr_b_q) begin
            sel_d   = 1'b1;
            phase_d = PhAddr;
          end else if (rx_byte_i == FlagByte) begin
            phase_d = PhFlag;
          end else begin
            phase_d = PhHunt;
          end
        end
        PhAddr: begin
          priority if (kind_hit) begin
            kind_d  = kind_match;
            phase_d = PhCtrl;
          end else if (rx_byte_i == FlagByte) begin
            phase_d = PhFlag;
          end else begin
            phase_d = PhHunt;
          end
        end
        PhCtrl: begin
          priority if (rx_byte_i == FlagByte) begin
            phase_d = PhFlag;
          end else if (rx_byte_i == (cur_addr ^ cur_code)) begin
            phase_d = PhBcc;
          end else begin
            phase_d = PhHunt;
          end
        end
        PhBcc: begin
          priority if (rx_byte_i == FlagByte) begin
            ds_in  = DsClear;
            end_do = 1'b1;
          end else if (kind_q < KindFirstSup) begin
            ds_in     = DsClear;
            esc_in    = 1'b0;
            data_path = 1'b1;
            phase_d   = PhData;
          end else begin
            phase_d = PhHunt;
          end
        end
        PhData: begin
          if (rx_byte_i == FlagByte) begin
            // A lone escape before the closing flag is kept as data.
            p1_do  = esc_q;
            p1_val = EscByte;
            end_do = 1'b1;
          end else begin
            data_path = 1'b1;
          end
        end
        default: phase_d = PhHunt;
      endcase
    end

    if (data_path) begin
      esc_d = 1'b0;
      if (esc_in) begin
        p1_do = 1'b1;
        if (rx_byte_i == EscFlag) begin
          p1_val = FlagByte;
        end else if (rx_byte_i == EscEsc) begin
          p1_val = EscByte;
        end else begin
          // Broken escape: keep the escape byte and treat this one afresh.
          p1_val = EscByte;
          if (rx_byte_i == EscByte) begin
            esc_d = 1'b1;
          end else begin
            p2_do  = 1'b1;
            p2_val = rx_byte_i;
          end
        end
      end else if (rx_byte_i == EscByte) begin
        esc_d = 1'b1;
      end else begin
        p1_do  = 1'b1;
        p1_val = rx_byte_i;
      end
    end

    pa     = push_fn(ds_in, p1_val);
    ds_mid = p1_do ? pa.s : ds_in;
    pb     = push_fn(ds_mid, p2_val);
    ds_fin = p2_do ? pb.s : ds_mid;
    e1     = p1_do && pa.emit;
    e2     = p2_do && pb.emit;

    ds_d = ds_fin;
    if (end_do) begin
      ds_d    = DsClear;
      esc_d   = 1'b0;
      phase_d = PhHunt;
    end
  end

  // End word contents, taken from the payload state after this byte.
  always_comb begin
    priority if (kind_q >= KindFirstSup) begin
      end_status = StCtrlOk;
      end_len    = '0;
    end else if (ds_fin.cnt > CntMax) begin
      end_status = StOverlong;
      end_len    = CntMax;
    end else if (!ds_fin.valid) begin
      end_status = StInfoErr;
      end_len    = '0;
    end else begin
      end_status = (ds_fin.held == ds_fin.chk) ? StInfoOk : StInfoErr;
      end_len    = ds_fin.cnt;
    end
    end_len_x = LenW'(end_len);
  end

  always_comb begin
    dr1 = '{is_end: 1'b0, data: pa.data, addr_sel: sel_q, kind: kind_q,
            status: StCtrlOk, len: '0};
    dr2 = '{is_end: 1'b0, data: pb.data, addr_sel: sel_q, kind: kind_q,
            status: StCtrlOk, len: '0};
    er  = '{is_end: 1'b1, data: '0, addr_sel: sel_q, kind: kind_q,
            status: end_status,
            len: (end_len_x > LenW'(LenSat)) ? LenFieldW'(LenSat)
                                             : end_len_x[LenFieldW-1:0]};
    slot0 = er;
    slot1 = er;
    n_wr  = 2'd0;
    priority if (e1) begin
      slot0 = dr1;
      if (e2) begin
        slot1 = dr2;
        n_wr  = 2'd2;
      end else if (end_do) begin
        slot1 = er;
        n_wr  = 2'd2;
      end else begin
        n_wr = 2'd1;
      end
    end else if (e2) begin
      slot0 = dr2;
      n_wr  = 2'd1;
    end else if (end_do) begin
      slot0 = er;
      n_wr  = 2'd1;
    end else begin
      n_wr = 2'd0;
    end
  end

  assign fill_d = fill_q + (PtrW+1)'(n_wr) - (PtrW+1)'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_a_q <= AddrARst;
      addr_b_q <= AddrBRst;
      info0_q  <= Info0Rst;
      info1_q  <= Info1Rst;
      sup_q    <= SupRst;
      phase_q  <= PhHunt;
      sel_q    <= 1'b0;
      kind_q   <= '0;
      esc_q    <= 1'b0;
      ds_q     <= DsClear;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CfgAddrA: addr_a_q <= cfg_data_i[DataW-1:0];
          CfgAddrB: addr_b_q <= cfg_data_i[DataW-1:0];
          CfgInfo0: info0_q  <= cfg_data_i[DataW-1:0];
          CfgInfo1: info1_q  <= cfg_data_i[DataW-1:0];
          CfgSup:   sup_q    <= cfg_data_i;
          default: ;
        endcase
      end
      phase_q  <= phase_d;
      sel_q    <= sel_d;
      kind_q   <= kind_d;
      esc_q    <= esc_d;
      ds_q     <= ds_d;
      wr_ptr_q <= wr_ptr_q + PtrW'(n_wr);
      rd_ptr_q <= rd_ptr_q + PtrW'(pop);
      fill_q   <= fill_d;
    end
  end

  // Queue storage carries payload only and needs no reset.
  always_ff @(posedge clk_i) begin
    if (n_wr != 2'd0) res_q[wr_ptr_q] <= slot0;
    if (n_wr == 2'd2) res_q[wr_ptr_q + 1'b1] <= slot1;
  end

  assign is_end_o      = res_q[rd_ptr_q].is_end;
  assign data_byte_o   = res_q[rd_ptr_q].data;
  assign address_sel_o = res_q[rd_ptr_q].addr_sel;
  assign ctrl_kind_o   = res_q[rd_ptr_q].kind;
  assign status_o      = res_q[rd_ptr_q].status;
  assign payload_len_o = res_q[rd_ptr_q].len;

endmodule

`default_nettype wire
